[rtl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Character codes that act as newline.
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  // Register reset values.
  localparam logic [7:0] TEXT_ATTR_RST   = 8'h1f;
  localparam logic [7:0] SCROLL_ATTR_RST = 8'h4f;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_TEXT_ATTR   = 1'b0,
    CFG_SCROLL_ATTR = 1'b1
  } tcw_cfg_idx_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       did_scroll;
  } tcw_out_t;

  typedef struct packed {
    tcw_cfg_idx_t index;
    logic [7:0]   value;
  } tcw_cfg_t;

  // What the held item asks for.
  typedef enum logic [2:0] {
    KIND_PUT_CHAR,
    KIND_NEWLINE,
    KIND_READ,
    KIND_CLEAR,
    KIND_NOP
  } tcw_kind_t;

  // How a cell read is formed from the RAM word.
  typedef enum logic [1:0] {
    RK_ZERO,    // cell never written since clear, or out of range
    RK_MEM,     // character and attribute from RAM
    RK_MEM_SA   // character from RAM, attribute from the latched scroll attribute
  } tcw_rdkind_t;

  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CLR,
    ST_DONE
  } tcw_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_item;
    logic write_char;
    logic next_row;
    logic home;
    logic start_read;
    logic clr_write;
    logic load_out;
    logic load_read;
  } tcw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    tcw_kind_t kind;
    logic      col_last;
    logic      clr_done;
    logic      out_free;
  } tcw_stat_t;

endpackage

`default_nettype wire

[rtl/tcw_ifs.sv]
// Valid/ready channel interfaces for input, result and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic    valid;
  logic    ready;
  tcw_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  tcw_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  tcw_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/text_console_writer.sv]
// Each transaction is taken in IDLE, executed in EXEC and answered from DONE or READ; a clear or
// line change first runs a sweep of NUM_COLS writes that clears one row in RAM. Transactions
// are handled one at a time, and a new one is taken only once the result register is free.
// Reset (rst_n low, synchronous): cursor home, attributes 0x1f and 0x4f, then a
// sweep of NUM_COLS writes clears the top row before the first transaction is accepted.
// Configuration transactions are accepted every cycle.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  // The screen is a ring of physical rows; a scroll moves the top-row pointer
  // instead of copying cells. Each row is wiped when the cursor enters it, so
  // cells below the cursor are known zero without clearing them. After a scroll
  // every attribute outside the freshly written part of the bottom row is the
  // scroll attribute latched at that moment, applied on read.

  tcw_cmd_t  cmd;
  tcw_stat_t stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

`default_nettype wire

[rtl/tcw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/tcw_ctrl.sv]
// Sequencing state machine for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tcw_stat_t stat,
  output tcw_cmd_t       cmd
);

  tcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT_CLR: if (stat.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid && stat.out_free) state_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (stat.kind)
          KIND_PUT_CHAR: state_nxt = stat.col_last ? ST_CLR : ST_DONE;
          KIND_NEWLINE:  state_nxt = ST_CLR;
          KIND_READ:     state_nxt = ST_READ;
          KIND_CLEAR:    state_nxt = ST_CLR;
          KIND_NOP:      state_nxt = ST_DONE;
          default:       state_nxt = ST_DONE;
        endcase
      end
      ST_READ:     state_nxt = ST_IDLE;
      ST_CLR:      if (stat.clr_done) state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT_CLR: cmd.clr_write = 1'b1;
      ST_IDLE: begin
        in_ready      = stat.out_free;
        cmd.take_item = in_valid && stat.out_free;
      end
      ST_EXEC: begin
        unique case (stat.kind)
          KIND_PUT_CHAR: begin
            cmd.write_char = 1'b1;
            cmd.next_row   = stat.col_last;
          end
          KIND_NEWLINE: cmd.next_row   = 1'b1;
          KIND_READ:    cmd.start_read = 1'b1;
          KIND_CLEAR:   cmd.home       = 1'b1;
          KIND_NOP:     ;
          default:      ;
        endcase
      end
      ST_READ: begin
        cmd.load_out  = 1'b1;
        cmd.load_read = 1'b1;
      end
      ST_CLR:  cmd.clr_write = 1'b1;
      ST_DONE: cmd.load_out  = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/tcw_datapath.sv]
// Cursor, row offset, cell RAM, configuration and result register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 24
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tcw_in_if.sink        in_ch,
  tcw_out_if.source     out_ch,
  tcw_cfg_if.sink       cfg_ch,
  input  wire tcw_cmd_t cmd,
  output tcw_stat_t     stat
);

  localparam int COL_W  = $clog2(NUM_COLS);
  localparam int ROW_W  = $clog2(NUM_ROWS);
  localparam int ROW_SW = ROW_W + 1;
  localparam int CELLS  = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  // Physical row of logical row r, given the physical row of the top line.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] r);
    logic [ROW_SW-1:0] s;
    s = {1'b0, base} + {1'b0, r};
    if (s >= ROW_SW'(NUM_ROWS)) s = s - ROW_SW'(NUM_ROWS);
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] prow);
    return ADDR_W'(prow) * ADDR_W'(NUM_COLS);
  endfunction

  tcw_in_t           item_r;
  tcw_kind_t         kind;
  logic [7:0]        ta_r, sa_r, sa_lat_r, sa_lat_nxt;
  logic [COL_W-1:0]  cx_r, cx_nxt;
  logic [ROW_W-1:0]  cy_r, cy_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              did_scroll_r, did_scroll_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  tcw_rdkind_t       rd_kind_r, rd_kind_nxt;
  tcw_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, cur_addr;
  logic [15:0]       ram_wdata, ram_rdata;
  logic              rd_in_range, rd_last_row, rd_before_cx, rd_seen;

  // Configuration: always ready, writes land directly in the registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ta_r <= TEXT_ATTR_RST;
      sa_r <= SCROLL_ATTR_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        CFG_TEXT_ATTR:   ta_r <= cfg_ch.data.value;
        CFG_SCROLL_ATTR: sa_r <= cfg_ch.data.value;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) item_r <= in_ch.data;
  end

  // Item decode.
  always_comb begin
    unique case (item_r.action)
      ACT_PUT: begin
        kind = (item_r.char_code == CH_LF || item_r.char_code == CH_CR) ?
               KIND_NEWLINE : KIND_PUT_CHAR;
      end
      ACT_READ:  kind = KIND_READ;
      ACT_CLEAR: kind = KIND_CLEAR;
      default:   kind = KIND_NOP;
    endcase
  end

  assign stat.kind     = kind;
  assign stat.col_last = (cx_r == COL_W'(NUM_COLS - 1));
  assign stat.clr_done = (clr_cnt_r == COL_W'(NUM_COLS - 1));
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign cur_addr = row_base(phys_row(top_r, cy_r)) + ADDR_W'(cx_r);

  // Read classification.
  assign rd_in_range  = (int'(item_r.read_row) < NUM_ROWS) &&
                        (int'(item_r.read_col) < NUM_COLS);
  assign rd_last_row  = (int'(item_r.read_row) == NUM_ROWS - 1);
  assign rd_before_cx = (int'(item_r.read_col) < int'(cx_r));
  assign rd_seen      = (int'(item_r.read_row) <= int'(cy_r));
  assign ram_raddr    = row_base(phys_row(top_r, ROW_W'(item_r.read_row))) +
                        ADDR_W'(item_r.read_col);

  always_comb begin
    if (!rd_in_range) begin
      rd_kind_nxt = RK_ZERO;
    end else if (!scrolled_r) begin
      rd_kind_nxt = rd_seen ? RK_MEM : RK_ZERO;
    end else begin
      rd_kind_nxt = (rd_last_row && rd_before_cx) ? RK_MEM : RK_MEM_SA;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_read) rd_kind_r <= rd_kind_nxt;
  end

  // RAM write port: character puts and row clearing.
  assign ram_we    = cmd.write_char || cmd.clr_write;
  assign ram_waddr = cmd.write_char ? cur_addr : clr_addr_r;
  assign ram_wdata = cmd.write_char ? {ta_r, item_r.char_code} : 16'h0000;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cursor, row offset and clear sweep.
  always_comb begin
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    top_nxt        = top_r;
    scrolled_nxt   = scrolled_r;
    sa_lat_nxt     = sa_lat_r;
    did_scroll_nxt = did_scroll_r;
    clr_addr_nxt   = clr_addr_r;
    clr_cnt_nxt    = clr_cnt_r;

    if (cmd.take_item) did_scroll_nxt = 1'b0;
    if (cmd.write_char) cx_nxt = cx_r + COL_W'(1);
    if (cmd.clr_write) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      clr_cnt_nxt  = clr_cnt_r + COL_W'(1);
    end
    if (cmd.next_row) begin
      cx_nxt      = '0;
      clr_cnt_nxt = '0;
      if (cy_r == ROW_W'(NUM_ROWS - 1)) begin
        // Scroll: the old top row becomes the new, cleared bottom row.
        top_nxt        = phys_row(top_r, ROW_W'(1));
        scrolled_nxt   = 1'b1;
        sa_lat_nxt     = sa_r;
        did_scroll_nxt = 1'b1;
        clr_addr_nxt   = row_base(top_r);
      end else begin
        cy_nxt       = cy_r + ROW_W'(1);
        clr_addr_nxt = row_base(phys_row(top_r, cy_r + ROW_W'(1)));
      end
    end
    if (cmd.home) begin
      cx_nxt       = '0;
      cy_nxt       = '0;
      scrolled_nxt = 1'b0;
      clr_cnt_nxt  = '0;
      clr_addr_nxt = row_base(top_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r         <= '0;
      cy_r         <= '0;
      top_r        <= '0;
      scrolled_r   <= 1'b0;
      did_scroll_r <= 1'b0;
      clr_addr_r   <= '0;
      clr_cnt_r    <= '0;
    end else begin
      cx_r         <= cx_nxt;
      cy_r         <= cy_nxt;
      top_r        <= top_nxt;
      scrolled_r   <= scrolled_nxt;
      did_scroll_r <= did_scroll_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sa_lat_r <= sa_lat_nxt;
  end

  // Result register.
  always_comb begin
    out_nxt            = out_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;
    if (cmd.load_out) begin
      out_valid_nxt      = 1'b1;
      out_nxt.cursor_col = 7'(cx_r);
      out_nxt.cursor_row = 5'(cy_r);
      out_nxt.did_scroll = did_scroll_r;
      out_nxt.cell_char  = 8'h00;
      out_nxt.cell_attr  = 8'h00;
      if (cmd.load_read) begin
        unique case (rd_kind_r)
          RK_ZERO: ;
          RK_MEM: begin
            out_nxt.cell_char = ram_rdata[7:0];
            out_nxt.cell_attr = ram_rdata[15:8];
          end
          RK_MEM_SA: begin
            out_nxt.cell_char = ram_rdata[7:0];
            out_nxt.cell_attr = sa_lat_r;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the text console writer: directed cases, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  // Screen geometry, kept equal to the instance parameters below.
  localparam int COLS  = 80;
  localparam int ROWS  = 24;
  localparam int CELLS = COLS * ROWS;

  // Action code with no defined operation.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Idle cycles tolerated with no transaction on any channel. The slowest
  // correct item is a line change with its row sweep, behind a send gap and a
  // result stall of up to MAX_GAP each; the post-reset row sweep comes on top.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles after the last result before the verdict.
  localparam int DRAIN_CYCLES   = 120;
  localparam int MAX_GAP        = 13;

  logic clk;
  logic rst_n;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();
  tcw_cfg_if cfg_ch();

  text_console_writer #(
    .NUM_COLS(COLS),
    .NUM_ROWS(ROWS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the console: cells hold {attribute, character}.
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_screen [CELLS];
  int unsigned shadow_col;
  int unsigned shadow_row;
  logic [7:0]  shadow_text_attr;
  logic [7:0]  shadow_scroll_attr;

  // Results predicted for accepted transactions, oldest first.
  tcw_out_t pending_results[$];

  int  error_count;
  int  quiet_cycles;
  // When set, both sides run back to back with no idle cycles.
  bit  burst_mode;

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("text_console_writer verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Console prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_shadow();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
    shadow_col = 0;
    shadow_row = 0;
  endfunction

  // Cursor to column 0 of the next row; past the last row the screen moves up,
  // the bottom row is blanked and every attribute becomes the scroll attribute.
  function automatic bit advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row < ROWS) return 1'b0;
    for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = '0;
    for (int i = 0; i < CELLS; i++) shadow_screen[i][15:8] = shadow_scroll_attr;
    shadow_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic tcw_out_t predict_console(tcw_in_t item);
    tcw_out_t    res;
    logic [15:0] cell_word;
    res = '0;
    case (item.action)
      ACT_PUT: begin
        if (item.char_code == CH_LF || item.char_code == CH_CR) begin
          res.did_scroll = advance_line();
        end else begin
          shadow_screen[shadow_row * COLS + shadow_col] = {shadow_text_attr, item.char_code};
          shadow_col++;
          if (shadow_col >= COLS) res.did_scroll = advance_line();
        end
      end
      ACT_READ: begin
        // Out-of-range coordinates read as an empty cell.
        if (item.read_row < ROWS && item.read_col < COLS) begin
          cell_word = shadow_screen[item.read_row * COLS + item.read_col];
          res.cell_char = cell_word[7:0];
          res.cell_attr = cell_word[15:8];
        end
      end
      ACT_CLEAR: clear_shadow();
      default: ;  // unused action: state untouched
    endcase
    res.cursor_col = shadow_col[6:0];
    res.cursor_row = shadow_row[4:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic tcw_in_t make_item(logic [1:0] action, logic [7:0] ch,
                                        logic [4:0] row, logic [6:0] col);
    tcw_in_t item;
    item.action    = action;
    item.char_code = ch;
    item.read_row  = row;
    item.read_col  = col;
    return item;
  endfunction

  // Mostly puts (with plenty of line breaks so scrolls occur) and in-range
  // reads; clears are rare so the screen fills up between them.
  function automatic tcw_in_t random_item();
    int unsigned pick;
    tcw_in_t     item;
    pick = $urandom_range(0, 999);
    item = make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    if (pick < 630) begin
      item.action = ACT_PUT;
      if ($urandom_range(0, 4) == 0) item.char_code = $urandom_range(0, 1) ? CH_LF : CH_CR;
    end else if (pick < 960) begin
      item.action = ACT_READ;
      if ($urandom_range(0, 6) != 0) begin
        item.read_row = 5'($urandom_range(0, ROWS - 1));
        item.read_col = 7'($urandom_range(0, COLS - 1));
      end
    end else if (pick < 965) begin
      item.action = ACT_CLEAR;
    end else begin
      item.action = ACT_UNUSED;
    end
    return item;
  endfunction

  // Send one input transaction and record its predicted result on acceptance.
  task automatic send_item(tcw_in_t item);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = item;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_console(item));
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write; only issued while the console is idle.
  task automatic write_reg(tcw_cfg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.data.index = idx;
    cfg_ch.data.value = value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_TEXT_ATTR) shadow_text_attr = value;
    else shadow_scroll_attr = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  initial begin : result_checker
    int       stall;
    tcw_out_t exp_res;
    out_ch.ready = 1'b0;
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing pending, actual %h", $time,
                 out_ch.data);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("cursor_col", exp_res.cursor_col, out_ch.data.cursor_col);
        check_field("cursor_row", exp_res.cursor_row, out_ch.data.cursor_row);
        check_field("cell_char",  exp_res.cell_char,  out_ch.data.cell_char);
        check_field("cell_attr",  exp_res.cell_attr,  out_ch.data.cell_attr);
        check_field("did_scroll", exp_res.did_scroll, out_ch.data.did_scroll);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Action 3 must report the cursor and touch nothing; reset screen is blank.
  task automatic test_unused_action();
    send_item(make_item(ACT_UNUSED, 8'hff, 5'h1f, 7'h7f));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'hff, 5'(ROWS - 1), 7'(COLS - 1)));
  endtask

  // Extreme characters land at the cursor with the text attribute.
  task automatic test_put_read();
    send_item(make_item(ACT_PUT, 8'h00, 5'h1f, 7'h7f));
    send_item(make_item(ACT_PUT, 8'hff, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, 8'h41, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd1));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd2));
  endtask

  // Coordinates past the screen edge read back as zero.
  task automatic test_read_out_of_range();
    send_item(make_item(ACT_READ, 8'h00, 5'(ROWS), 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'h1f, 7'd1));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'(COLS)));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'h7f));
  endtask

  // LF and CR move to the next row without storing anything.
  task automatic test_newline();
    send_item(make_item(ACT_PUT, CH_LF, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, CH_CR, 5'd0, 7'd0));
    send_item(make_item(ACT_PUT, 8'h7e, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd2, 7'd0));
  endtask

  // Clear blanks the screen and homes the cursor.
  task automatic test_clear_home();
    send_item(make_item(ACT_CLEAR, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd0, 7'd0));
    send_item(make_item(ACT_READ, 8'h00, 5'd2, 7'd0));
  endtask

  // Random traffic; idle behavior is redrawn every 50 transactions so that
  // gapped stretches and back-to-back stretches alternate.
  task automatic run_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_item(random_item());
    end
    burst_mode = 1'b0;
    wait_idle();
  endtask

  // Register extremes in both directions.
  task automatic test_attribute_extremes();
    write_reg(CFG_TEXT_ATTR, 8'h00);
    write_reg(CFG_SCROLL_ATTR, 8'hff);
    run_random_traffic(380);
    write_reg(CFG_TEXT_ATTR, 8'hff);
    write_reg(CFG_SCROLL_ATTR, 8'h00);
    run_random_traffic(380);
  endtask

  // Random register values; a scroll attribute change after a scroll must
  // leave existing cells alone.
  task automatic test_random_attributes();
    for (int p = 0; p < 2; p++) begin
      write_reg(CFG_TEXT_ATTR, 8'($urandom_range(0, 255)));
      write_reg(CFG_SCROLL_ATTR, 8'($urandom_range(0, 255)));
      run_random_traffic(390);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    error_count        = 0;
    quiet_cycles       = 0;
    burst_mode         = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data         = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    shadow_text_attr   = TEXT_ATTR_RST;
    shadow_scroll_attr = SCROLL_ATTR_RST;
    clear_shadow();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unused_action();
    test_put_read();
    test_read_out_of_range();
    test_newline();
    test_clear_home();
    wait_idle();
    test_attribute_extremes();
    test_random_attributes();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

endmodule
